// File: rtl/core/pls_pkg.sv
// ============================================================================
// pls_pkg: shared types and codes for the positional list store
// Operation codes, status codes and the control state type.
// ============================================================================
package pls_pkg;

    // operation codes on i_op
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;

    // status codes on o_status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_FINISH,
        S_DUMP
    } t_state;

endpackage

// File: rtl/core/pls_ram.sv
// ============================================================================
// pls_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module pls_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/positional_list_store_top.sv
// ============================================================================
// positional_list_store_top: ordered list store with positional edits
// Insert at a 1-based position, delete at a position, dump the whole list.
// ============================================================================
// An item is taken at a clock edge with start high and busy low. Entries live
// in one RAM with one read and one write port; insert and delete move the
// later entries one slot per cycle through a read/write-back pipeline, and a
// dump reads one entry per cycle. An insert or a delete keeps busy high while
// in S_SHIFT and S_FINISH, and a dump of a non-empty list while in S_DUMP; a
// rejected item, an empty dump or an unused op leaves busy low and its result
// appears in the next cycle. Each result beat is shown for one cycle with
// o_valid high and cannot be held off; a dump sends count beats on consecutive
// cycles, the last with o_last set. The register holding the result lets the
// next item be taken while that beat is still on the ports.
// ============================================================================
module positional_list_store_top #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_value,
    input  logic [5:0]         i_position,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_element,
    output logic               o_element_valid,
    output logic [5:0]         o_entry_count,
    output logic               o_last
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > 6) ? CW : 6) + 1;

    // control registers
    pls_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_left, n_left;
    logic            r_wpend, n_wpend;
    logic            r_ins, n_ins;
    logic            r_rlast, n_rlast;
    logic            r_valid, n_valid;

    // payload registers
    logic [AW-1:0]         r_src, n_src;
    logic [AW-1:0]         r_wadr, n_wadr;
    logic [AW-1:0]         r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic [1:0]            r_status, n_status;
    logic signed [31:0]    r_element, n_element;
    logic                  r_el_valid, n_el_valid;
    logic [5:0]            r_out_count, n_out_count;
    logic                  r_last, n_last;

    // RAM port signals
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic            accept;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;

    assign accept  = start && (r_state == pls_pkg::S_IDLE);
    assign pos_ext = CMPW'(i_position);
    assign cnt_ext = CMPW'(r_count);

    pls_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_src),
        .o_rdata (ram_rdata)
    );

    // next state, datapath and RAM control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_wpend     = r_wpend;
        n_ins       = r_ins;
        n_rlast     = r_rlast;
        n_valid     = 1'b0;
        n_src       = r_src;
        n_wadr      = r_wadr;
        n_pos       = r_pos;
        n_value     = r_value;
        n_status    = r_status;
        n_element   = r_element;
        n_el_valid  = r_el_valid;
        n_out_count = r_out_count;
        n_last      = r_last;
        ram_we      = 1'b0;
        ram_waddr   = r_wadr;
        ram_wdata   = ram_rdata;

        case (r_state)
            pls_pkg::S_IDLE: begin
                if (accept) begin
                    // single-result defaults; overridden where work starts
                    n_valid     = 1'b1;
                    n_status    = pls_pkg::ST_OK;
                    n_element   = '0;
                    n_el_valid  = 1'b0;
                    n_last      = 1'b1;
                    n_out_count = 6'(r_count);
                    n_wpend     = 1'b0;
                    case (i_op)
                        pls_pkg::OP_INSERT: begin
                            if (i_position == '0 || pos_ext > cnt_ext + 1'b1) begin
                                n_status = pls_pkg::ST_BAD_POS;
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_status = pls_pkg::ST_FULL;
                            end else begin
                                n_valid = 1'b0;
                                n_ins   = 1'b1;
                                n_left  = CW'(cnt_ext - pos_ext + 1'b1);
                                n_src   = AW'(r_count - 1'b1);
                                n_pos   = AW'(pos_ext - 1'b1);
                                n_value = DATA_WIDTH'($unsigned(i_value));
                                n_state = pls_pkg::S_SHIFT;
                            end
                        end
                        pls_pkg::OP_DELETE: begin
                            if (i_position == '0 || pos_ext > cnt_ext) begin
                                n_status = pls_pkg::ST_BAD_POS;
                            end else begin
                                n_valid = 1'b0;
                                n_ins   = 1'b0;
                                n_left  = CW'(cnt_ext - pos_ext);
                                n_src   = AW'(i_position);
                                n_state = pls_pkg::S_SHIFT;
                            end
                        end
                        pls_pkg::OP_DUMP: begin
                            if (r_count != '0) begin
                                n_valid = 1'b0;
                                n_left  = r_count;
                                n_src   = '0;
                                n_state = pls_pkg::S_DUMP;
                            end
                        end
                        default: begin
                            n_status = pls_pkg::ST_BAD_POS;
                        end
                    endcase
                end
            end

            pls_pkg::S_SHIFT: begin
                // write back the entry read last cycle one slot over
                ram_we = r_wpend;
                if (r_left != '0) begin
                    n_wpend = 1'b1;
                    n_wadr  = r_ins ? r_src + 1'b1 : r_src - 1'b1;
                    n_src   = r_ins ? r_src - 1'b1 : r_src + 1'b1;
                    n_left  = r_left - 1'b1;
                end else begin
                    n_wpend = 1'b0;
                    n_state = pls_pkg::S_FINISH;
                end
            end

            pls_pkg::S_FINISH: begin
                // drop the new value into the opened slot, report the count
                if (r_ins) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos;
                    ram_wdata = r_value;
                    n_count   = r_count + 1'b1;
                end else begin
                    n_count   = r_count - 1'b1;
                end
                n_valid     = 1'b1;
                n_status    = pls_pkg::ST_OK;
                n_element   = '0;
                n_el_valid  = 1'b0;
                n_last      = 1'b1;
                n_out_count = 6'(n_count);
                n_state     = pls_pkg::S_IDLE;
            end

            pls_pkg::S_DUMP: begin
                // read one entry per cycle, emit it the cycle after
                if (r_wpend) begin
                    n_valid     = 1'b1;
                    n_status    = pls_pkg::ST_OK;
                    n_element   = $signed(32'(ram_rdata));
                    n_el_valid  = 1'b1;
                    n_last      = r_rlast;
                    n_out_count = 6'(r_count);
                end
                if (r_left != '0) begin
                    n_wpend = 1'b1;
                    n_rlast = (r_left == CW'(1));
                    n_src   = r_src + 1'b1;
                    n_left  = r_left - 1'b1;
                end else begin
                    n_wpend = 1'b0;
                    n_state = pls_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = pls_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pls_pkg::S_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_wpend <= 1'b0;
            r_ins   <= 1'b0;
            r_rlast <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_wpend <= n_wpend;
            r_ins   <= n_ins;
            r_rlast <= n_rlast;
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_src       <= n_src;
        r_wadr      <= n_wadr;
        r_pos       <= n_pos;
        r_value     <= n_value;
        r_status    <= n_status;
        r_element   <= n_element;
        r_el_valid  <= n_el_valid;
        r_out_count <= n_out_count;
        r_last      <= n_last;
    end

    assign busy            = (r_state != pls_pkg::S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_element       = r_element;
    assign o_element_valid = r_el_valid;
    assign o_entry_count   = r_out_count;
    assign o_last          = r_last;

    // count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a dump never writes the RAM
    a_dump_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pls_pkg::S_DUMP) |-> !ram_we)
        else $error("RAM write during dump");

    // an element beat always carries ok status
    a_element_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_el_valid) |-> (r_status == pls_pkg::ST_OK))
        else $error("element beat with error status");

    // insert at a legal position into a full store reports full next cycle
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == pls_pkg::OP_INSERT && i_position != '0 &&
         pos_ext <= cnt_ext + 1'b1 && r_count == CW'(CAPACITY))
        |=> (r_valid && r_status == pls_pkg::ST_FULL && r_state == pls_pkg::S_IDLE))
        else $error("full insert not flagged");

endmodule
